>>> src/dfsr_pkg.sv
// Shared types and fixed field widths for the dual feed sequence race statistics block.
package dfsr_pkg;

	localparam int unsigned SEQ_IN_W  = 32;  // sequence field width on the stream
	localparam int unsigned NS_W      = 63;  // nanosecond timestamp and lead sum width
	localparam int unsigned CNT_OUT_W = 32;  // counter field width on the stream

	// One round as held in the input register. The timestamps are already reduced
	// to the lead of each feed, since a race is only scored on the round's own stamps.
	typedef struct packed {
		logic                a_offered;
		logic                a_parsed_ok;
		logic [SEQ_IN_W-1:0] a_sequence;
		logic                b_offered;
		logic                b_parsed_ok;
		logic [SEQ_IN_W-1:0] b_sequence;
		logic                a_earlier;
		logic                b_earlier;
		logic [NS_W-1:0]     lead_a_ns;
		logic [NS_W-1:0]     lead_b_ns;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic                 finished;
		logic                 want_next_a;
		logic                 want_next_b;
		logic [1:0]           out_of_sequence;
		logic [CNT_OUT_W-1:0] packets_a;
		logic [CNT_OUT_W-1:0] packets_b;
		logic [CNT_OUT_W-1:0] dropped_a;
		logic [CNT_OUT_W-1:0] dropped_b;
		logic [CNT_OUT_W-1:0] faster_a;
		logic [CNT_OUT_W-1:0] faster_b;
		logic [NS_W-1:0]      lead_total_a_ns;
		logic [NS_W-1:0]      lead_total_b_ns;
	} result_t;

endpackage

>>> src/dual_feed_sequence_race_stats_top.sv
// Top level of the dual feed sequence race statistics block.
//
// Each input beat is one lock-step round of two redundant sequenced feeds, A and B.
// A feed is read only when the block requested it in the previous round (both are
// requested after reset) and it offers an item; a read item that parsed replaces
// that feed's last sequence. After each round the feed or feeds with the lowest last
// sequence are requested again, and every round yields exactly one result beat with
// the request flags, the backward-sequence flags and all counters and lead sums as
// they stand after the round. Counters saturate at 2^COUNT_WIDTH-1 and are shown in
// their low 32 bits; lead sums saturate at 2^63-1. A round in which neither feed was
// read reports finished and changes nothing. The block takes one beat per clock
// cycle while the result is not stalled: the round is resolved by the compare and
// saturating-add logic between the input register and the result register, so a
// result beat is registered when its round leaves the input register, and while the
// result register is stalled the input register holds one more input beat.
module dual_feed_sequence_race_stats_top #(
	parameter int unsigned SEQ_WIDTH   = 32,  // stored sequence width, 8 to 64
	parameter int unsigned COUNT_WIDTH = 32   // internal counter width, 8 to 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input round.
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata from bit 0: a_sequence[31:0], a_time_ns[94:32], b_sequence[126:95],
	// b_time_ns[189:127], zero pad[191:190].
	input  logic [191:0] s_tdata,
	// tuser from bit 0: a_offered, a_parsed_ok, b_offered, b_parsed_ok.
	input  logic [3:0]   s_tuser,
	// Result.
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata from bit 0: packets_a[31:0], packets_b[63:32], dropped_a[95:64],
	// dropped_b[127:96], faster_a[159:128], faster_b[191:160],
	// lead_total_a_ns[254:192], lead_total_b_ns[317:255], zero pad[319:318].
	output logic [319:0] m_tdata,
	// tuser from bit 0: finished, want_next_a, want_next_b, out_of_sequence[4:3].
	output logic [4:0]   m_tuser
);

	logic [dfsr_pkg::NS_W-1:0] a_time, b_time;
	logic [dfsr_pkg::NS_W:0]   diff_ab, diff_ba;
	dfsr_pkg::item_t           item_d, item_s1;
	logic                      valid_s1;
	dfsr_pkg::result_t         result_d, result_q;
	logic                      out_valid_q;
	logic                      advance, step, accept_in;

	// The timestamps only matter as the lead of one feed over the other in the
	// same round, so both leads are formed before the input register.
	assign a_time  = s_tdata[94:32];
	assign b_time  = s_tdata[189:127];
	assign diff_ab = {1'b0, a_time} - {1'b0, b_time};
	assign diff_ba = {1'b0, b_time} - {1'b0, a_time};

	always_comb begin
		item_d.a_offered   = s_tuser[0];
		item_d.a_parsed_ok = s_tuser[1];
		item_d.b_offered   = s_tuser[2];
		item_d.b_parsed_ok = s_tuser[3];
		item_d.a_sequence  = s_tdata[31:0];
		item_d.b_sequence  = s_tdata[126:95];
		item_d.a_earlier   = !diff_ba[dfsr_pkg::NS_W] && (diff_ba != '0);
		item_d.b_earlier   = !diff_ab[dfsr_pkg::NS_W] && (diff_ab != '0);
		item_d.lead_a_ns   = diff_ba[dfsr_pkg::NS_W-1:0];
		item_d.lead_b_ns   = diff_ab[dfsr_pkg::NS_W-1:0];
	end

	// The round in the input register is resolved whenever the result register
	// is empty or being drained; the input register refills in the same cycle.
	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign accept_in = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= item_d;
		end
	end

	dfsr_core #(
		.SEQ_WIDTH   (SEQ_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {result_q.out_of_sequence, result_q.want_next_b,
		result_q.want_next_a, result_q.finished};
	assign m_tdata  = {2'b00, result_q.lead_total_b_ns, result_q.lead_total_a_ns,
		result_q.faster_b, result_q.faster_a, result_q.dropped_b, result_q.dropped_a,
		result_q.packets_b, result_q.packets_a};

endmodule

>>> src/dfsr_core.sv
// Per-round state and statistics update for the dual feed sequence race statistics block.
module dfsr_core #(
	parameter int unsigned SEQ_WIDTH   = 32,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  dfsr_pkg::item_t  item,
	output dfsr_pkg::result_t result
);

	logic [SEQ_WIDTH-1:0]   last_seq_a_q, last_seq_b_q;
	logic                   request_a_q, request_b_q;
	logic [COUNT_WIDTH-1:0] packets_a_q, packets_b_q;
	logic [COUNT_WIDTH-1:0] drops_a_q, drops_b_q;
	logic [COUNT_WIDTH-1:0] wins_a_q, wins_b_q;
	logic [dfsr_pkg::NS_W-1:0] lead_sum_a_q, lead_sum_b_q;

	logic                   read_a, read_b, finished;
	logic [SEQ_WIDTH-1:0]   seq_a_d, seq_b_d;
	logic                   request_a_d, request_b_d;
	logic                   up_a, up_b, both_up;
	logic [COUNT_WIDTH-1:0] packets_a_d, packets_b_d;
	logic [COUNT_WIDTH-1:0] drops_a_d, drops_b_d;
	logic [COUNT_WIDTH-1:0] wins_a_d, wins_b_d;
	logic [dfsr_pkg::NS_W-1:0] lead_sum_a_d, lead_sum_b_d;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [dfsr_pkg::NS_W-1:0] ns_add(
		input logic [dfsr_pkg::NS_W-1:0] s,
		input logic [dfsr_pkg::NS_W-1:0] d
	);
		logic [dfsr_pkg::NS_W:0] t;
		t = {1'b0, s} + {1'b0, d};
		return t[dfsr_pkg::NS_W] ? {dfsr_pkg::NS_W{1'b1}} : t[dfsr_pkg::NS_W-1:0];
	endfunction

	always_comb begin
		read_a   = request_a_q & item.a_offered;
		read_b   = request_b_q & item.b_offered;
		finished = !read_a && !read_b;

		// A feed that was not read, or did not parse, keeps its last sequence.
		seq_a_d = (read_a && item.a_parsed_ok) ? SEQ_WIDTH'(item.a_sequence) : last_seq_a_q;
		seq_b_d = (read_b && item.b_parsed_ok) ? SEQ_WIDTH'(item.b_sequence) : last_seq_b_q;

		request_a_d = finished ? request_a_q : (seq_a_d <= seq_b_d);
		request_b_d = finished ? request_b_q : (seq_b_d <= seq_a_d);

		up_a    = last_seq_a_q < seq_a_d;
		up_b    = last_seq_b_q < seq_b_d;
		both_up = up_a && up_b;

		packets_a_d  = up_a ? sat_inc(packets_a_q) : packets_a_q;
		packets_b_d  = up_b ? sat_inc(packets_b_q) : packets_b_q;
		drops_a_d    = drops_a_q;
		drops_b_d    = drops_b_q;
		wins_a_d     = wins_a_q;
		wins_b_d     = wins_b_q;
		lead_sum_a_d = lead_sum_a_q;
		lead_sum_b_d = lead_sum_b_q;

		// Both stamps are this round's own when both feeds advanced.
		if (both_up) begin
			priority if (seq_a_d < seq_b_d) begin
				drops_b_d = sat_inc(drops_b_q);
			end else if (seq_b_d < seq_a_d) begin
				drops_a_d = sat_inc(drops_a_q);
			end else if (item.a_earlier) begin
				wins_a_d     = sat_inc(wins_a_q);
				lead_sum_a_d = ns_add(lead_sum_a_q, item.lead_a_ns);
			end else if (item.b_earlier) begin
				wins_b_d     = sat_inc(wins_b_q);
				lead_sum_b_d = ns_add(lead_sum_b_q, item.lead_b_ns);
			end else begin
				// Level stamps on level sequences: neither feed wins the race.
			end
		end

		result.finished           = finished;
		result.want_next_a        = request_a_d;
		result.want_next_b        = request_b_d;
		result.out_of_sequence[0] = !up_a && (seq_a_d != last_seq_a_q);
		result.out_of_sequence[1] = !up_b && (seq_b_d != last_seq_b_q);
		result.packets_a          = dfsr_pkg::CNT_OUT_W'(packets_a_d);
		result.packets_b          = dfsr_pkg::CNT_OUT_W'(packets_b_d);
		result.dropped_a          = dfsr_pkg::CNT_OUT_W'(drops_a_d);
		result.dropped_b          = dfsr_pkg::CNT_OUT_W'(drops_b_d);
		result.faster_a           = dfsr_pkg::CNT_OUT_W'(wins_a_d);
		result.faster_b           = dfsr_pkg::CNT_OUT_W'(wins_b_d);
		result.lead_total_a_ns    = lead_sum_a_d;
		result.lead_total_b_ns    = lead_sum_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_a_q <= '0;
			last_seq_b_q <= '0;
			request_a_q  <= 1'b1;
			request_b_q  <= 1'b1;
			packets_a_q  <= '0;
			packets_b_q  <= '0;
			drops_a_q    <= '0;
			drops_b_q    <= '0;
			wins_a_q     <= '0;
			wins_b_q     <= '0;
			lead_sum_a_q <= '0;
			lead_sum_b_q <= '0;
		end else if (step) begin
			last_seq_a_q <= seq_a_d;
			last_seq_b_q <= seq_b_d;
			request_a_q  <= request_a_d;
			request_b_q  <= request_b_d;
			packets_a_q  <= packets_a_d;
			packets_b_q  <= packets_b_d;
			drops_a_q    <= drops_a_d;
			drops_b_q    <= drops_b_d;
			wins_a_q     <= wins_a_d;
			wins_b_q     <= wins_b_d;
			lead_sum_a_q <= lead_sum_a_d;
			lead_sum_b_q <= lead_sum_b_d;
		end
	end

endmodule
